FILE: rtl/dpsd_pkg.sv
package dpsd_pkg;

   // Field and datapath widths.
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned PIXEL_W     = 16;
   localparam int unsigned CLAMP_W     = 17;
   localparam int unsigned SUM_W       = 18;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned DELTA7_W    = 7;
   localparam int unsigned DELTA14_W   = 14;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_CLAMP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_CLAMP = 2'd2;

   // Configuration reset values.
   localparam logic                       MODE_RESET       = 1'b1;
   localparam logic signed [CLAMP_W-1:0]  LOW_CLAMP_RESET  = 17'sd0;
   localparam logic signed [CLAMP_W-1:0]  HIGH_CLAMP_RESET = 17'sd65535;

   // Code byte bits: a clear top bit marks a short delta, then the next bit
   // separates a literal from a long delta.
   localparam int unsigned CODE_LONG_BIT    = 7;
   localparam int unsigned CODE_LITERAL_BIT = 6;

   // Configuration as seen by the decoder.
   typedef struct packed {
      logic                      compressed_mode;
      logic signed [CLAMP_W-1:0] low_clamp;
      logic signed [CLAMP_W-1:0] high_clamp;
      logic                      restart;
   } cfg_type;

endpackage

FILE: rtl/dpsd_csr.sv
module dpsd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dpsd_pkg::CLAMP_W-1:0]          csr_wdata,
   output dpsd_pkg::cfg_type                     cfg
);
   import dpsd_pkg::*;

   logic                      mode_ff, mode_in;
   logic signed [CLAMP_W-1:0] low_ff, low_in;
   logic signed [CLAMP_W-1:0] high_ff, high_in;
   logic                      write;
   logic                      restart;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   // Register decode; an unknown index is ignored.
   always_comb begin
      mode_in = mode_ff;
      low_in  = low_ff;
      high_in = high_ff;
      restart = 1'b0;
      if (write) begin
         unique case (csr_index)
            CSR_MODE: begin
               mode_in = csr_wdata[0];
               restart = 1'b1;
            end
            CSR_LOW_CLAMP:  low_in  = $signed(csr_wdata);
            CSR_HIGH_CLAMP: high_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         low_ff  <= LOW_CLAMP_RESET;
         high_ff <= HIGH_CLAMP_RESET;
      end else begin
         mode_ff <= mode_in;
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // A mode write also sends the decoder back to a code byte.
   assign cfg.compressed_mode = mode_ff;
   assign cfg.low_clamp       = low_ff;
   assign cfg.high_clamp      = high_ff;
   assign cfg.restart         = restart;

endmodule

FILE: rtl/dpsd_decode.sv
module dpsd_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  dpsd_pkg::cfg_type                cfg,
   input  logic                             in_vld,
   input  logic [dpsd_pkg::BYTE_W-1:0]      in_byte,
   output logic                             in_take,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dpsd_pkg::PIXEL_W-1:0]     rsp_pixel
);
   import dpsd_pkg::*;

   typedef enum logic [1:0] {
      PH_CODE,
      PH_LIT_HI,
      PH_PAIR_LO,
      PH_D14_LO
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [BYTE_W-1:0]         held_ff, held_in;
   logic signed [CLAMP_W-1:0] running_ff, running_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [PIXEL_W-1:0]        rsp_pixel_ff, rsp_pixel_in;

   logic                      emit;
   logic                      use_clamp;
   logic signed [SUM_W-1:0]   running_ext;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   low_ext;
   logic signed [SUM_W-1:0]   high_ext;
   logic signed [SUM_W-1:0]   raised;
   logic signed [SUM_W-1:0]   clamped;
   logic [PIXEL_W-1:0]        raw_pixel;

   // The byte moves on whenever the result register is free or draining.
   assign in_take = in_vld && (!rsp_vld_ff || rsp_ready);

   assign running_ext = SUM_W'(running_ff);
   assign low_ext     = SUM_W'(cfg.low_clamp);
   assign high_ext    = SUM_W'(cfg.high_clamp);
   assign raw_pixel   = {held_ff, in_byte};

   // Byte decode: next phase, held byte and the unclamped value.
   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      sum       = running_ext;
      emit      = 1'b0;
      use_clamp = 1'b0;
      unique case (phase_ff)
         PH_CODE: begin
            if (!cfg.compressed_mode) begin
               held_in  = in_byte;
               phase_in = PH_PAIR_LO;
            end else if (!in_byte[CODE_LONG_BIT]) begin
               sum       = running_ext + SUM_W'($signed(in_byte[DELTA7_W-1:0]));
               emit      = 1'b1;
               use_clamp = 1'b1;
            end else if (in_byte[CODE_LITERAL_BIT]) begin
               phase_in = PH_LIT_HI;
            end else begin
               held_in  = in_byte;
               phase_in = PH_D14_LO;
            end
         end
         PH_LIT_HI: begin
            held_in  = in_byte;
            phase_in = PH_PAIR_LO;
         end
         PH_PAIR_LO: begin
            phase_in  = PH_CODE;
            emit      = 1'b1;
            use_clamp = cfg.compressed_mode;
            sum       = SUM_W'({held_ff, in_byte});
         end
         PH_D14_LO: begin
            phase_in  = PH_CODE;
            emit      = 1'b1;
            use_clamp = 1'b1;
            sum       = running_ext
                      + SUM_W'($signed({held_ff[DELTA14_W-BYTE_W-1:0], in_byte}));
         end
         default: phase_in = PH_CODE;
      endcase
   end

   // Raise to the low bound first, then lower to the high bound.
   assign raised  = (sum < low_ext) ? low_ext : sum;
   assign clamped = (raised > high_ext) ? high_ext : raised;

   // State update and result register.
   always_comb begin
      running_in   = running_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      if (in_take && emit) begin
         rsp_vld_in = 1'b1;
         if (use_clamp) begin
            running_in   = clamped[CLAMP_W-1:0];
            rsp_pixel_in = clamped[PIXEL_W-1:0];
         end else begin
            rsp_pixel_in = raw_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CODE;
         held_ff    <= '0;
         running_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (cfg.restart) begin
            phase_ff <= PH_CODE;
         end else if (in_take) begin
            phase_ff <= phase_in;
         end
         if (in_take) begin
            held_ff <= held_in;
         end
         running_ff <= running_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

FILE: rtl/delta_pixel_stream_decoder.sv
// Channel   Ports                                  Direction  Moves
// req       req_valid, req_ready, req_data_byte    in         one stream byte
// rsp       rsp_valid, rsp_ready, rsp_pixel        out        one 16-bit pixel
// csr       csr_valid, csr_ready, csr_index,       in         one register write
//           csr_wdata
//
// One byte is taken per cycle while the result is not stalled; a pixel is offered
// once the byte that completes it moves from the input register into the
// result register.
// Code bytes that start a literal or a long delta give no pixel.
// Reset restores the configuration defaults and clears the running value.
// A stalled result holds the pipeline only once both registers are full.
module delta_pixel_stream_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dpsd_pkg::BYTE_W-1:0]           req_data_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dpsd_pkg::PIXEL_W-1:0]          rsp_pixel,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dpsd_pkg::CLAMP_W-1:0]          csr_wdata
);
   import dpsd_pkg::*;

   cfg_type           cfg;
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_take;

   dpsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register: refills in the same cycle that its byte moves on.
   assign req_ready = !in_vld_ff || in_take;

   always_comb begin
      in_vld_in  = in_vld_ff && !in_take;
      in_byte_in = in_byte_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      in_byte_ff <= in_byte_in;
   end

   dpsd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_vld    (in_vld_ff),
      .in_byte   (in_byte_ff),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pixel (rsp_pixel)
   );

endmodule
